### hdl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg: shared constants, types and helpers for the tag canonicalizer
// Sizes of the canonical buffer and subtag buffer, subtag kinds, character
// classes and the casing rule used when a subtag is copied out.
// ----------------------------------------------------------------------------
package ltc_pkg;

   // buffer sizes
   localparam int TAG_CAP    = 32;
   localparam int LANG_CAP   = 9;
   localparam int REGION_CAP = 4;
   localparam int SUBTAG_MAX = 8;

   // derived widths
   localparam int CANON_AW = $clog2(TAG_CAP);
   localparam int CL_W     = $clog2(TAG_CAP + 1);
   localparam int SUB_AW   = $clog2(SUBTAG_MAX);
   localparam int SL_W     = $clog2(SUBTAG_MAX + 1);
   localparam int IC_W     = $clog2(2 * TAG_CAP + 2);
   localparam int CMP_W    = CL_W + 1;

   // subtag kinds
   localparam logic [2:0] KIND_LANG    = 3'd0;
   localparam logic [2:0] KIND_SCRIPT  = 3'd1;
   localparam logic [2:0] KIND_REGION  = 3'd2;
   localparam logic [2:0] KIND_VARIANT = 3'd3;
   localparam logic [2:0] KIND_SEP     = 3'd4;

   // field flag bits
   localparam int HAVE_LANG   = 0;
   localparam int HAVE_SCRIPT = 1;
   localparam int HAVE_REGION = 2;

   // separators
   localparam logic [7:0] CH_HYPHEN     = 8'h2d;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

   // result of classifying a finished subtag
   typedef struct packed {
      logic            err;
      logic [2:0]      kind;
      logic [2:0]      flags_set;
      logic            sep;
      logic [CL_W-1:0] base;
   } cls_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // region upper, script title, everything else lower
   function automatic logic [7:0] case_char(input logic [7:0] c, input logic [2:0] kind,
                                             input logic first);
      logic up;
      logic [7:0] r;
      up = (kind == KIND_REGION) || (kind == KIND_SCRIPT && first);
      r  = c;
      if (up && c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'd32;
      end else if (!up && c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

### hdl/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ltc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/ltc_classify.sv
// ----------------------------------------------------------------------------
// ltc_classify: subtag classification
// Decides the kind of a finished subtag, whether it is legal, whether a
// hyphen goes in front of it and where its first character lands.
// ----------------------------------------------------------------------------
module ltc_classify
   import ltc_pkg::*;
(
   input  logic [SL_W-1:0] len,
   input  logic            all_alpha,
   input  logic            all_digit,
   input  logic [2:0]      flags,
   input  logic [CL_W-1:0] canon_len,
   output cls_type         cls
);

   logic [CMP_W-1:0] n_w;
   logic [CMP_W-1:0] cl_w;
   logic [CMP_W-1:0] base_w;
   logic             sep;
   logic             kind_err;
   logic             buf_err;
   logic [2:0]       kind;
   logic [2:0]       flags_set;

   assign n_w    = CMP_W'(len);
   assign cl_w   = CMP_W'(canon_len);
   assign sep    = canon_len != '0;
   assign base_w = cl_w + CMP_W'(sep);

   // kind selection, same precedence as the field order of a tag
   always_comb begin
      kind_err  = 1'b0;
      kind      = KIND_VARIANT;
      flags_set = '0;
      priority if (!flags[HAVE_LANG]) begin
         kind_err = (n_w < CMP_W'(2)) || !all_alpha || (n_w + CMP_W'(1) > CMP_W'(LANG_CAP));
         kind = KIND_LANG;
         flags_set[HAVE_LANG] = 1'b1;
      end else if (n_w == CMP_W'(4) && all_alpha && !flags[HAVE_SCRIPT]
                   && !flags[HAVE_REGION]) begin
         kind = KIND_SCRIPT;
         flags_set[HAVE_SCRIPT] = 1'b1;
      end else if (!flags[HAVE_REGION] && ((n_w == CMP_W'(2) && all_alpha)
                   || (n_w == CMP_W'(3) && all_digit))) begin
         kind_err = n_w + CMP_W'(1) > CMP_W'(REGION_CAP);
         kind = KIND_REGION;
         flags_set[HAVE_REGION] = 1'b1;
      end else begin
         kind = KIND_VARIANT;
      end
   end

   // room check: optional hyphen, the subtag, and one spare slot
   assign buf_err = (sep && (cl_w + CMP_W'(1) >= CMP_W'(TAG_CAP)))
                    || (base_w + n_w + CMP_W'(1) > CMP_W'(TAG_CAP));

   always_comb begin
      cls.err       = kind_err || buf_err;
      cls.kind      = kind;
      cls.flags_set = flags_set;
      cls.sep       = sep;
      cls.base      = base_w[CL_W-1:0];
   end

endmodule

### hdl/language_tag_canonicalizer.sv
// ----------------------------------------------------------------------------
// language_tag_canonicalizer: language tag parser and canonicalizer
// Collects a tag byte by byte, casts each subtag into its canonical case and
// streams the canonical tag (or one reject result) after the final byte.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req      in         req_valid/req_ready req_char_in, req_end_of_tag
//  rsp      out        rsp_valid/rsp_ready rsp_out_char, rsp_subtag_kind,
//                                          rsp_status, rsp_last_char
//
//  A letter or digit is written into the subtag RAM. A separator closes the
//  subtag, which is classified, then copied into the canonical RAM, one
//  character per cycle. After the final byte of an accepted tag each result
//  character is read from the canonical RAM, then loaded into the output
//  register; a rejected tag gives one reject result. Synchronous reset clears
//  the sequencer state but not the copy/emit counters, result payload or RAMs.
//  A stalled result holds in the output register; the next tag's bytes are
//  taken meanwhile, and its results wait until the register frees up.
// ----------------------------------------------------------------------------
module language_tag_canonicalizer
   import ltc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_tag,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic [2:0] rsp_subtag_kind,
   output logic       rsp_status,
   output logic       rsp_last_char
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FIN  = 3'd1;
   localparam logic [2:0] ST_COPY = 3'd2;
   localparam logic [2:0] ST_END  = 3'd3;
   localparam logic [2:0] ST_EMRD = 3'd4;
   localparam logic [2:0] ST_EMLD = 3'd5;
   localparam logic [2:0] ST_ERR  = 3'd6;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [IC_W-1:0]     ic_ff, ic_in;
   logic [SL_W-1:0]     sl_ff, sl_in;
   logic [CL_W-1:0]     cl_ff, cl_in;
   logic [2:0]          flags_ff, flags_in;
   logic                err_ff, err_in;
   logic                al_ff, al_in;
   logic                dg_ff, dg_in;
   logic                lastp_ff, lastp_in;
   logic [SUB_AW-1:0]   cp_idx_ff, cp_idx_in;
   logic [SL_W-1:0]     cp_len_ff, cp_len_in;
   logic [2:0]          kind_ff, kind_in;
   logic [CANON_AW-1:0] em_ff, em_in;
   logic                rv_ff, rv_in;

   // output payload
   logic [7:0] rc_ff, rc_in;
   logic [2:0] rk_ff, rk_in;
   logic       rs_ff, rs_in;
   logic       rl_ff, rl_in;

   // RAM ports
   logic                sub_we;
   logic [SUB_AW-1:0]   sub_waddr, sub_raddr;
   logic [7:0]          sub_rdata;
   logic                can_we;
   logic [CANON_AW-1:0] can_waddr;
   logic [10:0]         can_wdata, can_rdata;

   logic            accept;
   logic            is_sep;
   logic            err_now;
   logic            out_free;
   logic            cp_done;
   logic            em_last;
   logic            tag_done;
   logic [SL_W-1:0] cp_next;
   cls_type         cls;

   ltc_ram #(.WIDTH(8), .DEPTH(SUBTAG_MAX)) u_sub_ram (
      .clock  (clock),
      .wr_en  (sub_we),
      .wr_addr(sub_waddr),
      .wr_data(req_char_in),
      .rd_addr(sub_raddr),
      .rd_data(sub_rdata)
   );

   ltc_ram #(.WIDTH(11), .DEPTH(TAG_CAP)) u_canon_ram (
      .clock  (clock),
      .wr_en  (can_we),
      .wr_addr(can_waddr),
      .wr_data(can_wdata),
      .rd_addr(em_ff),
      .rd_data(can_rdata)
   );

   ltc_classify u_classify (
      .len      (sl_ff),
      .all_alpha(al_ff),
      .all_digit(dg_ff),
      .flags    (flags_ff),
      .canon_len(cl_ff),
      .cls      (cls)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign is_sep    = req_char_in == CH_HYPHEN || req_char_in == CH_UNDERSCORE;
   assign out_free  = !rv_ff || rsp_ready;
   assign cp_next   = SL_W'(cp_idx_ff) + SL_W'(1);
   assign cp_done   = cp_next == cp_len_ff;
   assign em_last   = CL_W'(em_ff) + CL_W'(1) == cl_ff;

   // tag finished: last result loaded into the output register
   assign tag_done  = (state_ff == ST_EMLD && out_free && em_last)
                      || (state_ff == ST_ERR && out_free);

   assign sub_waddr = sl_ff[SUB_AW-1:0];
   assign sub_raddr = (state_ff == ST_COPY) ? cp_next[SUB_AW-1:0] : '0;

   // byte accounting on an accepted request
   always_comb begin
      ic_in   = ic_ff;
      err_now = err_ff;
      if (accept) begin
         if (ic_ff <= IC_W'(2 * TAG_CAP)) begin
            ic_in = ic_ff + IC_W'(1);
         end
         if (ic_in > IC_W'(2 * TAG_CAP)) begin
            err_now = 1'b1;
         end
      end
      if (tag_done) begin
         ic_in = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sl_in     = sl_ff;
      cl_in     = cl_ff;
      flags_in  = flags_ff;
      err_in    = err_ff;
      al_in     = al_ff;
      dg_in     = dg_ff;
      lastp_in  = lastp_ff;
      cp_idx_in = cp_idx_ff;
      cp_len_in = cp_len_ff;
      kind_in   = kind_ff;
      em_in     = em_ff;
      rv_in     = rv_ff && !rsp_ready;
      rc_in     = rc_ff;
      rk_in     = rk_ff;
      rs_in     = rs_ff;
      rl_in     = rl_ff;
      sub_we    = 1'b0;
      can_we    = 1'b0;
      can_waddr = cl_ff[CANON_AW-1:0];
      can_wdata = {KIND_SEP, CH_HYPHEN};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in   = err_now;
               lastp_in = req_end_of_tag;
               if (!err_now && !is_sep) begin
                  if (sl_ff >= SL_W'(SUBTAG_MAX)
                      || !(is_alpha(req_char_in) || is_digit(req_char_in))) begin
                     err_in = 1'b1;
                  end else begin
                     sub_we = 1'b1;
                     sl_in  = sl_ff + SL_W'(1);
                     al_in  = al_ff && is_alpha(req_char_in);
                     dg_in  = dg_ff && is_digit(req_char_in);
                  end
               end
               if (req_end_of_tag && err_in) begin
                  state_in = ST_ERR;
               end else if (req_end_of_tag || (!err_now && is_sep)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            sl_in = '0;
            al_in = 1'b1;
            dg_in = 1'b1;
            if (sl_ff == '0) begin
               state_in = lastp_ff ? ST_END : ST_IDLE;
            end else if (cls.err) begin
               err_in   = 1'b1;
               state_in = lastp_ff ? ST_ERR : ST_IDLE;
            end else begin
               flags_in  = flags_ff | cls.flags_set;
               can_we    = cls.sep;
               cl_in     = cls.base;
               cp_idx_in = '0;
               cp_len_in = sl_ff;
               kind_in   = cls.kind;
               state_in  = ST_COPY;
            end
         end
         ST_COPY: begin
            can_we    = 1'b1;
            can_wdata = {kind_ff, case_char(sub_rdata, kind_ff, cp_idx_ff == '0)};
            cl_in     = cl_ff + CL_W'(1);
            cp_idx_in = cp_next[SUB_AW-1:0];
            if (cp_done) begin
               state_in = lastp_ff ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            em_in = '0;
            if (err_ff || !flags_ff[HAVE_LANG] || cl_ff == '0) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_EMRD;
            end
         end
         ST_EMRD: begin
            state_in = ST_EMLD;
         end
         ST_EMLD: begin
            if (out_free) begin
               rv_in = 1'b1;
               rc_in = can_rdata[7:0];
               rk_in = can_rdata[10:8];
               rs_in = 1'b0;
               rl_in = em_last;
               em_in = em_ff + CANON_AW'(1);
               state_in = em_last ? ST_IDLE : ST_EMRD;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rc_in    = '0;
               rk_in    = KIND_LANG;
               rs_in    = 1'b1;
               rl_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // tag finished: back to the empty-tag state
      if (tag_done) begin
         sl_in    = '0;
         cl_in    = '0;
         flags_in = '0;
         err_in   = 1'b0;
         al_in    = 1'b1;
         dg_in    = 1'b1;
         lastp_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ic_ff    <= '0;
         sl_ff    <= '0;
         cl_ff    <= '0;
         flags_ff <= '0;
         err_ff   <= 1'b0;
         al_ff    <= 1'b1;
         dg_ff    <= 1'b1;
         lastp_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ic_ff    <= ic_in;
         sl_ff    <= sl_in;
         cl_ff    <= cl_in;
         flags_ff <= flags_in;
         err_ff   <= err_in;
         al_ff    <= al_in;
         dg_ff    <= dg_in;
         lastp_ff <= lastp_in;
         rv_ff    <= rv_in;
      end
   end

   // copy/emit counters and result payload
   always_ff @(posedge clock) begin
      cp_idx_ff <= cp_idx_in;
      cp_len_ff <= cp_len_in;
      kind_ff   <= kind_in;
      em_ff     <= em_in;
      rc_ff     <= rc_in;
      rk_ff     <= rk_in;
      rs_ff     <= rs_in;
      rl_ff     <= rl_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_char    = rc_ff;
   assign rsp_subtag_kind = rk_ff;
   assign rsp_status      = rs_ff;
   assign rsp_last_char   = rl_ff;

   // a reject is always the only, hence final, result of its tag
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rs_ff |-> rl_ff)
      else $error("reject result without last_char");

   // canonical length never passes the buffer size
   a_canon_bound: assert property (@(posedge clock) disable iff (reset)
      cl_ff <= CL_W'(TAG_CAP))
      else $error("canonical length out of range");

   // copy never runs past the subtag it was started for
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> SL_W'(cp_idx_ff) < cp_len_ff)
      else $error("copy index past subtag length");

   // a new result is loaded only into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> $stable(rc_ff) && $stable(rs_ff) && $stable(rl_ff))
      else $error("stalled result overwritten");

endmodule
